### rtl/rria_pkg.sv
// ----------------------------------------------------------------------------
// rria_pkg
// Shared types and constants for the round-robin identifier allocator.
// ----------------------------------------------------------------------------
package rria_pkg;

    localparam int ID_OUT_W = 10;
    localparam int MAP_W    = 32;
    localparam int BIT_W    = 5;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BUSY   = 2'd1,
        STATUS_BADREL = 2'd2
    } t_status;

    typedef struct packed {
        logic                cmd;
        logic [ID_OUT_W-1:0] release_id;
    } t_in_word;

    typedef struct packed {
        logic [ID_OUT_W-1:0] granted_id;
        t_status             status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACQ_SCAN,
        S_ACQ_WR,
        S_REL_RD,
        S_REL_CHK,
        S_RESULT
    } t_ctl_state;

    typedef struct packed {
        logic    load_in;
        logic    clr_step;
        logic    scan_start;
        logic    scan_step;
        logic    acq_write;
        logic    rel_read;
        logic    rel_write;
        logic    res_load;
        logic    res_grant;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic found;
        logic exhausted;
        logic rel_range_bad;
        logic rel_active;
        logic out_free;
    } t_dp_stat;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [MAP_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/rria_ctl.sv
// ----------------------------------------------------------------------------
// rria_ctl
// Sequencer: clearing pass, acquire scan, release check, result hand-off.
// ----------------------------------------------------------------------------
module rria_ctl
    import rria_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_in_cmd == CMD_ACQUIRE) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_ACQ_SCAN;
                    end else begin
                        n_state = S_REL_RD;
                    end
                end
            end
            S_ACQ_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.found) begin
                    n_state = S_ACQ_WR;
                end else if (i_stat.exhausted) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STATUS_BUSY;
                    n_state          = S_RESULT;
                end
            end
            S_ACQ_WR: begin
                o_cmd.acq_write  = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_grant  = 1'b1;
                o_cmd.res_status = STATUS_OK;
                n_state          = S_RESULT;
            end
            S_REL_RD: begin
                if (i_stat.rel_range_bad) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STATUS_BADREL;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.rel_read = 1'b1;
                    n_state        = S_REL_CHK;
                end
            end
            S_REL_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.rel_active) begin
                    o_cmd.rel_write  = 1'b1;
                    o_cmd.res_status = STATUS_OK;
                end else begin
                    o_cmd.res_status = STATUS_BADREL;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### rtl/rria_dp.sv
// ----------------------------------------------------------------------------
// rria_dp
// Datapath: active bitmap memory (32 ids per row), scan pipeline, last
// issued id, result and output registers.
// ----------------------------------------------------------------------------
module rria_dp
    import rria_pkg::*;
#(
    parameter int MAX_ID = 1023
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int ID_W       = $clog2(MAX_ID + 1);
    localparam int NWORDS     = MAX_ID / MAP_W + 1;
    localparam int ADDR_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SCAN_WORDS = NWORDS + 1;
    localparam int CNT_W      = $clog2(SCAN_WORDS + 1);
    localparam int LAST_BITS  = MAX_ID % MAP_W + 1;
    localparam logic [MAP_W-1:0] LAST_MASK = {MAP_W{1'b1}} >> (MAP_W - LAST_BITS);
    localparam int CMP_W      = 17;

    logic [MAP_W-1:0] mem [NWORDS];

    t_in_word         r_item;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ID_W-1:0]  r_last;
    logic [ADDR_W-1:0] r_rd_word;
    logic [CNT_W-1:0] r_issued;
    logic [BIT_W-1:0] r_start_bit;
    logic             r_chk_valid;
    logic             r_chk_first;
    logic [ADDR_W-1:0] r_chk_word;
    logic [MAP_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_hit_word;
    logic [MAP_W-1:0] r_hit_data;
    logic [ID_W-1:0]  r_hit_id;
    logic [ID_W-1:0]  r_res_id;
    t_status          r_res_status;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic [ID_W-1:0]   next_id;
    logic              issue;
    logic [ADDR_W-1:0] rd_word_inc;
    logic [MAP_W-1:0]  vmask;
    logic [MAP_W-1:0]  free_bits;
    logic [BIT_W-1:0]  free_bit;
    logic [ADDR_W-1:0] rel_word;
    logic [BIT_W-1:0]  rel_bit;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [MAP_W-1:0]  wr_data;

    assign next_id     = (r_last < ID_W'(MAX_ID)) ? r_last + 1'b1 : ID_W'(1);
    assign issue       = r_issued < CNT_W'(SCAN_WORDS);
    assign rd_word_inc = (r_rd_word == ADDR_W'(NWORDS - 1)) ? '0 : r_rd_word + 1'b1;
    assign rel_word    = ADDR_W'(r_item.release_id >> BIT_W);
    assign rel_bit     = r_item.release_id[BIT_W-1:0];

    always_comb begin
        vmask = '1;
        if (r_chk_word == ADDR_W'(NWORDS - 1)) begin
            vmask = vmask & LAST_MASK;
        end
        if (r_chk_word == '0) begin
            vmask[0] = 1'b0;
        end
        free_bits = ~r_rd_data & vmask
                  & (r_chk_first ? ({MAP_W{1'b1}} << r_start_bit) : {MAP_W{1'b1}});
        free_bit  = lowest_set(free_bits);
    end

    assign o_stat.clr_last      = r_clr_addr == ADDR_W'(NWORDS - 1);
    assign o_stat.found         = r_chk_valid && (|free_bits);
    assign o_stat.exhausted     = !r_chk_valid && !issue;
    assign o_stat.rel_range_bad = (r_item.release_id == '0)
                               || (CMP_W'(r_item.release_id) > CMP_W'(MAX_ID));
    assign o_stat.rel_active    = r_rd_data[rel_bit];
    assign o_stat.out_free      = !r_out_valid || !i_out_stall;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_rd_word;
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (i_cmd.scan_step && issue) begin
            rd_en = 1'b1;
        end
        if (i_cmd.rel_read) begin
            rd_en   = 1'b1;
            rd_addr = rel_word;
        end
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end
        if (i_cmd.acq_write) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_word;
            wr_data = r_hit_data;
        end
        if (i_cmd.rel_write) begin
            wr_en   = 1'b1;
            wr_addr = rel_word;
            wr_data = r_rd_data & ~(MAP_W'(1) << rel_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_last      <= '0;
            r_issued    <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.acq_write) begin
                r_last <= r_hit_id;
            end
            if (i_cmd.scan_start) begin
                r_issued    <= '0;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_valid <= issue;
                if (issue) begin
                    r_issued <= r_issued + 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_word;
        end
        if (i_cmd.scan_start) begin
            r_rd_word   <= ADDR_W'(next_id >> BIT_W);
            r_start_bit <= BIT_W'(next_id);
        end else if (i_cmd.scan_step && issue) begin
            r_rd_word   <= rd_word_inc;
            r_chk_word  <= r_rd_word;
            r_chk_first <= r_issued == '0;
        end
        if (i_cmd.scan_step && o_stat.found) begin
            r_hit_word <= r_chk_word;
            r_hit_data <= r_rd_data | (MAP_W'(1) << free_bit);
            r_hit_id   <= ID_W'({r_chk_word, free_bit});
        end
        if (i_cmd.res_load) begin
            r_res_id     <= i_cmd.res_grant ? r_hit_id : '0;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out_word.granted_id <= ID_OUT_W'(r_res_id);
            r_out_word.status     <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### rtl/round_robin_id_allocator.sv
// ----------------------------------------------------------------------------
// round_robin_id_allocator
// Hands out identifiers 1..MAX_ID round-robin from an active bitmap and
// takes them back on release.
//
//   channel  direction  handshake                 word
//   input    in         i_in_valid / o_in_stall   i_in_word  (cmd, release_id)
//   output   out        o_out_valid / i_out_stall o_out_word (granted_id, status)
//
// Acquire: the bitmap memory is read one 32-bit row per cycle, starting at the
// row that holds the id after the last issued one.
// Release: row read, check and write back, result; an out-of-range id goes
// straight to the result. After reset a clearing pass zeroes the bitmap;
// the input stalls meanwhile. One word in flight; the next is taken once
// its result sits in the output register, also while that output is stalled.
// ----------------------------------------------------------------------------
module round_robin_id_allocator
    import rria_pkg::*;
#(
    parameter int MAX_ID = 1023
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rria_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_word.cmd),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    rria_dp #(
        .MAX_ID (MAX_ID)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != STATUS_OK) |-> o_out_word.granted_id == '0)
        else $error("identifier granted with non-ok status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a word in work");
`endif

endmodule
